// ----- rtl/npe_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// npe_pkg: shared types and constants of the NDR primitive encoder
// Command codes, configuration register indexes, the job descriptor passed
// from the front to the back, and the alignment size mapping.
// ----------------------------------------------------------------------------
package npe_pkg;

  localparam int OFFSET_BITS_DEF = 32;

  // job queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic [31:0] PTR_BASE          = 32'h0002_0000;
  localparam logic [63:0] LOW32_MASK        = 64'h0000_0000_FFFF_FFFF;
  localparam logic [31:0] BUFFER_SIZE_RESET = 32'd4096;

  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_BIG_ENDIAN  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NDR64_MODE  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_ALIGN    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BUFFER_SIZE = 4'd3;

  typedef enum logic [3:0] {
    CMD_BYTE    = 4'd0,
    CMD_U16     = 4'd1,
    CMD_U32     = 4'd2,
    CMD_U64     = 4'd3,
    CMD_LONG    = 4'd4,
    CMD_ULONG   = 4'd5,
    CMD_ALIGN   = 4'd6,
    CMD_TRAILER = 4'd7,
    CMD_UPTR    = 4'd8,
    CMD_RESTART = 4'd9
  } cmd_t;

  typedef struct packed {
    logic        big_endian;
    logic        ndr64_mode;
    logic        no_align;
    logic [31:0] buffer_size;
  } cfg_t;

  // one command, fully resolved: zero pad bytes, then value bytes in send
  // order (lowest byte first), then a status beat if the command overflowed
  typedef struct packed {
    logic [2:0]  pad_cnt;
    logic [3:0]  val_cnt;
    logic        ovf;
    logic [63:0] bytes;
  } job_t;

  // alignment size as requested -> power of two actually used
  function automatic logic [3:0] map_size(input logic [3:0] s, input logic ndr64);
    logic [3:0] r;
    case (s)
      4'd0, 4'd1: r = 4'd1;
      4'd2:       r = 4'd2;
      4'd3:       r = ndr64 ? 4'd4 : 4'd2;
      4'd4:       r = 4'd4;
      4'd5:       r = ndr64 ? 4'd8 : 4'd4;
      default:    r = 4'd8;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/npe_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// npe_front: command classifier
// Resolves each accepted command into a job: pad length, value bytes in send
// order and overflow. Owns the write offset and the pointer counter.
// ----------------------------------------------------------------------------
module npe_front #(
  parameter int OFFSET_BITS = npe_pkg::OFFSET_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [3:0]       command,
  input  logic [63:0]      value,
  input  logic [3:0]       align_size,
  input  npe_pkg::cfg_t    cfg,
  output logic             push,
  output npe_pkg::job_t    job
);

  localparam int OW = OFFSET_BITS + 1;
  localparam logic [31:0] LIMIT = 32'((64'(1) << OFFSET_BITS) - 64'(1));

  logic [OFFSET_BITS-1:0] write_offset, write_offset_next;
  logic [29:0]            pointer_counter, pointer_counter_next;
  logic [OFFSET_BITS-1:0] cap, room;
  logic [3:0]             n, psize;
  logic [2:0]             mask, pad, pad_room;
  logic [63:0]            v, rev, ordered;
  logic [OW-1:0]          sum_pad, sum_val, cap_w;
  logic                   pad_ovf, val_ovf, restart, cap_above;

  assign cap = (cfg.buffer_size > LIMIT) ? LIMIT[OFFSET_BITS-1:0]
                                         : cfg.buffer_size[OFFSET_BITS-1:0];

  // decode
  always_comb begin
    n = 4'd0;
    psize = 4'd1;
    v = value;
    restart = 1'b0;
    pointer_counter_next = pointer_counter;
    case (npe_pkg::cmd_t'(command))
      npe_pkg::CMD_BYTE: begin
        n = 4'd1;
        v = {56'd0, value[7:0]};
      end
      npe_pkg::CMD_U16: begin
        n = 4'd2;
        v = {48'd0, value[15:0]};
      end
      npe_pkg::CMD_U32: begin
        n = 4'd4;
        v = value & npe_pkg::LOW32_MASK;
      end
      npe_pkg::CMD_U64: begin
        n = 4'd8;
      end
      npe_pkg::CMD_LONG: begin
        if (cfg.ndr64_mode) begin
          n = 4'd8;
          v = {{32{value[31]}}, value[31:0]};
        end else begin
          n = 4'd4;
          v = value & npe_pkg::LOW32_MASK;
        end
      end
      npe_pkg::CMD_ULONG: begin
        n = cfg.ndr64_mode ? 4'd8 : 4'd4;
        v = value & npe_pkg::LOW32_MASK;
      end
      npe_pkg::CMD_ALIGN: begin
        psize = npe_pkg::map_size(align_size, cfg.ndr64_mode);
      end
      npe_pkg::CMD_TRAILER: begin
        if (cfg.ndr64_mode) psize = npe_pkg::map_size(align_size, 1'b1);
      end
      npe_pkg::CMD_UPTR: begin
        n = cfg.ndr64_mode ? 4'd8 : 4'd4;
        if (value != 64'd0) begin
          v = {32'd0, {pointer_counter, 2'b00} | npe_pkg::PTR_BASE};
          pointer_counter_next = pointer_counter + 30'd1;
        end else begin
          v = 64'd0;
        end
      end
      npe_pkg::CMD_RESTART: begin
        restart = 1'b1;
      end
      default: ;
    endcase
    if (n != 4'd0) psize = n;
  end

  // padding and capacity checks; an offset already past a shrunk buffer
  // only fails once a pad or value byte is actually due
  assign mask      = 3'(psize - 4'd1);
  assign pad       = cfg.no_align ? 3'd0 : ((3'd0 - write_offset[2:0]) & mask);
  assign sum_pad   = {1'b0, write_offset} + OW'(pad);
  assign sum_val   = sum_pad + OW'(n);
  assign cap_w     = {1'b0, cap};
  assign pad_ovf   = (pad != 3'd0) && (sum_pad > cap_w);
  assign val_ovf   = (n != 4'd0) && (sum_val > cap_w);
  assign cap_above = cap > write_offset;
  assign room      = cap - write_offset;
  assign pad_room  = cap_above ? room[2:0] : 3'd0;

  // byte order: back always sends the low byte first
  always_comb begin
    for (int i = 0; i < 8; i++) rev[8*i +: 8] = v[8*(7-i) +: 8];
    case (n)
      4'd2:    ordered = {48'd0, rev[63:48]};
      4'd4:    ordered = {32'd0, rev[63:32]};
      4'd8:    ordered = rev;
      default: ordered = v;
    endcase
    if (!cfg.big_endian) ordered = v;
  end

  always_comb begin
    job.bytes = ordered;
    if (pad_ovf) begin
      job.pad_cnt = pad_room;
      job.val_cnt = 4'd0;
      job.ovf = 1'b1;
      write_offset_next = cap_above ? cap : write_offset;
    end else if (val_ovf) begin
      job.pad_cnt = pad;
      job.val_cnt = 4'd0;
      job.ovf = 1'b1;
      write_offset_next = sum_pad[OFFSET_BITS-1:0];
    end else begin
      job.pad_cnt = pad;
      job.val_cnt = n;
      job.ovf = 1'b0;
      write_offset_next = sum_val[OFFSET_BITS-1:0];
    end
    if (restart) write_offset_next = '0;
  end

  assign push = accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      write_offset <= '0;
      pointer_counter <= '0;
    end else if (accept) begin
      write_offset <= write_offset_next;
      pointer_counter <= restart ? 30'd0 : pointer_counter_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/npe_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// npe_queue: job queue
// Small FIFO of resolved jobs between the front and the back.
// ----------------------------------------------------------------------------
module npe_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  npe_pkg::job_t din,
  input  logic          pop,
  output npe_pkg::job_t dout,
  output logic          full,
  output logic          empty
);

  localparam int PW = npe_pkg::QPTR_W;

  npe_pkg::job_t   entries [npe_pkg::QDEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [PW:0]     count;

  assign full  = count == (PW+1)'(npe_pkg::QDEPTH);
  assign empty = count == '0;
  assign dout  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= din;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PW'(1);
      if (pop) rd_ptr <= rd_ptr + PW'(1);
      case ({push, pop})
        2'b10:   count <= count + (PW+1)'(1);
        2'b01:   count <= count - (PW+1)'(1);
        default: ;
      endcase
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full job queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("pop from empty job queue");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (PW+1)'(npe_pkg::QDEPTH))
    else $error("job queue count out of range");

endmodule
`default_nettype wire

// ----- rtl/npe_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// npe_back: byte sequencer
// Plays a job out as output beats, one per ready cycle: zero pad, value bytes,
// then a status beat when needed. Output register parts it from the sink.
// ----------------------------------------------------------------------------
module npe_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  npe_pkg::job_t q_head,
  output logic          pop,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [7:0]    m_tdata,
  output logic [1:0]    m_tuser,
  output logic          m_tlast
);

  npe_pkg::job_t cur, cur_next;
  logic          cur_valid;
  logic          advance, emit;
  logic [7:0]    beat_byte;
  logic          beat_bv, beat_last, beat_status;

  assign advance = !m_tvalid || m_tready;
  assign emit    = advance && cur_valid;
  assign pop     = !q_empty && (!cur_valid || (emit && beat_last));

  always_comb begin
    cur_next = cur;
    beat_byte = 8'd0;
    beat_bv = 1'b1;
    beat_status = 1'b0;
    if (cur.pad_cnt != 3'd0) begin
      beat_last = (cur.pad_cnt == 3'd1) && (cur.val_cnt == 4'd0) && !cur.ovf;
      cur_next.pad_cnt = cur.pad_cnt - 3'd1;
    end else if (cur.val_cnt != 4'd0) begin
      beat_byte = cur.bytes[7:0];
      beat_last = cur.val_cnt == 4'd1;
      cur_next.bytes = {8'd0, cur.bytes[63:8]};
      cur_next.val_cnt = cur.val_cnt - 4'd1;
    end else begin
      // status-only beat
      beat_bv = 1'b0;
      beat_last = 1'b1;
      beat_status = cur.ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (advance) m_tvalid <= cur_valid;
      if (pop) begin
        cur_valid <= 1'b1;
      end else if (emit && beat_last) begin
        cur_valid <= 1'b0;
      end
    end
    if (emit) begin
      m_tdata <= beat_byte;
      m_tuser <= {beat_status, beat_bv};
      m_tlast <= beat_last;
    end
    if (pop) begin
      cur <= q_head;
    end else if (emit) begin
      cur <= cur_next;
    end
  end

  a_status_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tlast && !m_tuser[0])
    else $error("overflow status on a non-final or byte beat");
  a_empty_beat_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tlast)
    else $error("status-only beat not marked last");
  a_ovf_no_value: assert property (@(posedge clk) disable iff (rst)
    cur_valid && cur.ovf |-> cur.val_cnt == 4'd0)
    else $error("overflowed job still carries value bytes");
  a_val_bound: assert property (@(posedge clk) disable iff (rst)
    cur_valid |-> cur.val_cnt <= 4'd8)
    else $error("value byte count out of range");

endmodule
`default_nettype wire

// ----- rtl/ndr_primitive_encoder.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ndr_primitive_encoder: NDR primitive marshalling engine
// Turns push commands (byte, u16/u32/u64, long, ulong, align, trailer align,
// unique pointer, restart) into an aligned byte stream with overflow status.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake            payload
//  -------  ---  -------------------  --------------------------------------
//  cfg      in   cfg_valid/cfg_ready  cfg_index (register), cfg_data
//  s        in   s_tvalid/s_tready    tuser: command; tdata: value, align_size
//  m        out  m_tvalid/m_tready    tdata: out_byte; tuser: byte_valid,
//                                     status; tlast: last
//
//  Beats: one output beat per cycle while m_tready is high; a command takes
//  pad + value bytes beats (1 to 15), or one status beat when it ends bare;
//  an overflow sends the pad bytes that still fit, then one status beat.
//  The single byte lane of the back sequencer sets that figure;
//  the front classifies one command per cycle into a 4-deep job queue while it has room.
//  Reset (rst, synchronous): offset and pointer counter cleared, config
//  back to little endian, NDR, aligned, buffer size 4096; queue empty.
//  Stalls: s_tready drops only when the job queue is full; m_tready low
//  holds the output register while the front keeps taking commands.
//  cfg_ready is always high; write config only while the block is idle.
//
module ndr_primitive_encoder #(
  parameter int OFFSET_BITS = npe_pkg::OFFSET_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [npe_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_data,
  // command beats
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [71:0]                    s_tdata,  // [63:0] value, [67:64] align_size, rest 0
  input  logic [3:0]                     s_tuser,  // [3:0] command
  // output byte beats
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [7:0]                     m_tdata,  // [7:0] out_byte
  output logic [1:0]                     m_tuser,  // [0] byte_valid, [1] status
  output logic                           m_tlast
);

  npe_pkg::cfg_t cfg;
  npe_pkg::job_t front_job, q_head;
  logic          accept, push, pop, q_full, q_empty;

  // config registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.big_endian  <= 1'b0;
      cfg.ndr64_mode  <= 1'b0;
      cfg.no_align    <= 1'b0;
      cfg.buffer_size <= npe_pkg::BUFFER_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        npe_pkg::CFG_BIG_ENDIAN:  cfg.big_endian  <= cfg_data[0];
        npe_pkg::CFG_NDR64_MODE:  cfg.ndr64_mode  <= cfg_data[0];
        npe_pkg::CFG_NO_ALIGN:    cfg.no_align    <= cfg_data[0];
        npe_pkg::CFG_BUFFER_SIZE: cfg.buffer_size <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  npe_front #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .command    (s_tuser),
    .value      (s_tdata[63:0]),
    .align_size (s_tdata[67:64]),
    .cfg        (cfg),
    .push       (push),
    .job        (front_job)
  );

  npe_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (front_job),
    .pop   (pop),
    .dout  (q_head),
    .full  (q_full),
    .empty (q_empty)
  );

  npe_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_head   (q_head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule
`default_nettype wire

// ----- tb/ndr_primitive_encoder_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ndr_primitive_encoder_test: self-checking bench for the NDR primitive encoder
// Walks a short table of commands and register settings, then random command
// phases under several configurations. Every output beat is checked against
// a local marshalling model; both stream sides idle at random and the output
// side holds off once for a long stretch so the job queue backs up.
// ----------------------------------------------------------------------------
module ndr_primitive_encoder_test;

  localparam int TB_OFFSET_BITS = npe_pkg::OFFSET_BITS_DEF;
  localparam int LIMIT_CYCLES   = 200000;
  localparam int HOLD_CYCLES    = 300;
  localparam int TAIL_CYCLES    = 20;
  localparam int RAND_PHASES    = 5;
  localparam int PHASE_ITEMS    = 15;
  localparam int QUIET_FIRST    = 30;  // random items without idling
  localparam int QUIET_END      = 60;
  localparam int HOLD_AT        = 70;  // random item that starts the hold-off

  // command codes the block treats as no-ops
  localparam logic [3:0] CMD_SPARE_LO = 4'd10;
  localparam logic [3:0] CMD_SPARE    = 4'd12;
  localparam logic [3:0] CMD_SPARE_HI = 4'd15;

  // one expected output beat
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
    logic       status;
  } beat_t;

  typedef enum logic {ROW_CMD, ROW_MODE} row_kind_t;

  // directed row; a mode row carries {buffer_size, 29'b0, no_align, ndr64, big}
  // in value
  typedef struct packed {
    row_kind_t   kind;
    logic [3:0]  cmd;
    logic [63:0] value;
    logic [3:0]  asz;
    logic        typed;
    logic [4:0]  t_count;
    logic [7:0]  t_data;
    logic        t_status;
  } row_t;

  logic clk;
  logic rst       = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [npe_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata  = '0;  // [63:0] value, [67:64] align_size
  logic [3:0]  s_tuser  = '0;  // [3:0] command
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;        // [7:0] out_byte
  logic [1:0]  m_tuser;        // [0] byte_valid, [1] status
  logic        m_tlast;

  // model state and register shadows
  logic [31:0] stream_offset = '0;
  logic [29:0] uptr_counter  = '0;
  logic        mode_be       = 1'b0;
  logic        mode_n64      = 1'b0;
  logic        mode_noalign  = 1'b0;
  logic [31:0] mode_bufsize  = npe_pkg::BUFFER_SIZE_RESET;

  beat_t beats_of_cmd[$];     // beats of the command just marshalled
  beat_t expected_stream[$];  // beats not yet seen on the output
  row_t  dir_rows[$];

  int    mismatch_count = 0;
  int    beat_index     = 0;
  int    cycle_count    = 0;
  bit    quiet          = 1'b0;
  logic  hold_req       = 1'b0;

  ndr_primitive_encoder i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h, want %0h", what, got, want);
    mismatch_count++;
  endtask

  // ---- marshalling model ---------------------------------------------------

  // requested alignment -> power of two in use
  function automatic logic [3:0] align_bytes(input logic [3:0] req);
    case (req)
      4'd0, 4'd1: return 4'd1;
      4'd2, 4'd4: return req;
      4'd3:       return mode_n64 ? 4'd4 : 4'd2;
      4'd5:       return mode_n64 ? 4'd8 : 4'd4;
      default:    return 4'd8;
    endcase
  endfunction

  // usable message bytes, capped by the offset width
  function automatic logic [32:0] room();
    logic [32:0] cap;
    cap = (33'd1 << TB_OFFSET_BITS) - 33'd1;
    return ({1'b0, mode_bufsize} < cap) ? {1'b0, mode_bufsize} : cap;
  endfunction

  // zero padding up to the alignment; each pad byte is checked on its own
  function automatic bit pad_for(input logic [3:0] req);
    logic [31:0] mask;
    logic [31:0] pad;
    if (mode_noalign) return 1'b1;
    mask = {28'd0, align_bytes(req)} - 32'd1;
    pad  = (32'd0 - stream_offset) & mask;
    while (pad != 32'd0) begin
      if ({1'b0, stream_offset} + 33'd1 > room()) return 1'b0;
      beats_of_cmd.push_back(beat_t'{8'h00, 1'b1, 1'b0, 1'b0});
      stream_offset = stream_offset + 32'd1;
      pad = pad - 32'd1;
    end
    return 1'b1;
  endfunction

  // align to n, then n value bytes; a value that does not fit sends nothing
  function automatic bit put_value(input logic [63:0] v, input int n);
    logic [63:0] sh;
    int          idx;
    if (!pad_for(n[3:0])) return 1'b0;
    if ({1'b0, stream_offset} + 33'(n) > room()) return 1'b0;
    for (int i = 0; i < n; i++) begin
      idx = mode_be ? (n - 1 - i) : i;
      sh  = v >> (8 * idx);
      beats_of_cmd.push_back(beat_t'{sh[7:0], 1'b1, 1'b0, 1'b0});
    end
    stream_offset = stream_offset + 32'(n);
    return 1'b1;
  endfunction

  function automatic bit put_ulong(input logic [31:0] v);
    return put_value({32'd0, v}, mode_n64 ? 8 : 4);
  endfunction

  // expected beats of one command, appended to the expected stream
  task automatic marshal_command(input logic [3:0] cmd, input logic [63:0] val,
                                 input logic [3:0] asz);
    logic [31:0] ref_id;
    bit          ok;
    beats_of_cmd.delete();
    ok = 1'b1;
    case (cmd)
      npe_pkg::CMD_BYTE:  ok = put_value({56'd0, val[7:0]}, 1);
      npe_pkg::CMD_U16:   ok = put_value({48'd0, val[15:0]}, 2);
      npe_pkg::CMD_U32:   ok = put_value({32'd0, val[31:0]}, 4);
      npe_pkg::CMD_U64:   ok = put_value(val, 8);
      npe_pkg::CMD_LONG: begin
        if (mode_n64) ok = put_value({{32{val[31]}}, val[31:0]}, 8);
        else ok = put_value({32'd0, val[31:0]}, 4);
      end
      npe_pkg::CMD_ULONG: ok = put_ulong(val[31:0]);
      npe_pkg::CMD_ALIGN: ok = pad_for(asz);
      npe_pkg::CMD_TRAILER: begin
        if (mode_n64) ok = pad_for(asz);
      end
      npe_pkg::CMD_UPTR: begin
        // counter moves on for any non-null pointer, overflow or not
        ref_id = 32'd0;
        if (val != 64'd0) begin
          ref_id       = {uptr_counter, 2'b00} | npe_pkg::PTR_BASE;
          uptr_counter = uptr_counter + 30'd1;
        end
        ok = put_ulong(ref_id);
      end
      npe_pkg::CMD_RESTART: begin
        stream_offset = 32'd0;
        uptr_counter  = 30'd0;
      end
      default: ;
    endcase
    if (!ok) beats_of_cmd.push_back(beat_t'{8'h00, 1'b0, 1'b1, 1'b1});
    else if (beats_of_cmd.size() == 0)
      beats_of_cmd.push_back(beat_t'{8'h00, 1'b0, 1'b1, 1'b0});
    else beats_of_cmd[$].last = 1'b1;
    foreach (beats_of_cmd[k]) expected_stream.push_back(beats_of_cmd[k]);
  endtask

  // ---- table rows ------------------------------------------------------------

  function automatic row_t cmd_row(input logic [3:0] cmd, input logic [63:0] val,
                                   input logic [3:0] asz);
    row_t r;
    r = '0;
    r.kind  = ROW_CMD;
    r.cmd   = cmd;
    r.value = val;
    r.asz   = asz;
    return r;
  endfunction

  // command with beat count, final byte and final status typed in
  function automatic row_t typed_row(input logic [3:0] cmd, input logic [63:0] val,
                                     input logic [3:0] asz, input logic [4:0] cnt,
                                     input logic [7:0] data, input logic st);
    row_t r;
    r = cmd_row(cmd, val, asz);
    r.typed    = 1'b1;
    r.t_count  = cnt;
    r.t_data   = data;
    r.t_status = st;
    return r;
  endfunction

  function automatic row_t mode_row(input logic be, input logic n64, input logic na,
                                    input logic [31:0] bs);
    row_t r;
    r = '0;
    r.kind  = ROW_MODE;
    r.value = {bs, 29'd0, na, n64, be};
    return r;
  endfunction

  // ---- drivers -------------------------------------------------------------

  // called just after a rising edge; leaves tvalid high after the accept beat
  task automatic send_command(input logic [3:0] cmd, input logic [63:0] val,
                              input logic [3:0] asz);
    while (!quiet && $urandom_range(0, 99) < 7) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'd0, asz, val};
    s_tuser  <= cmd;
    marshal_command(cmd, val, asz);
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic cfg_beat(input logic [npe_pkg::CFG_IDX_W-1:0] idx,
                          input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // registers change only once the block has drained
  task automatic set_mode(input logic be, input logic n64, input logic na,
                          input logic [31:0] bs);
    s_tvalid <= 1'b0;
    while (expected_stream.size() != 0) @(posedge clk);
    cfg_beat(npe_pkg::CFG_BIG_ENDIAN, {31'd0, be});
    cfg_beat(npe_pkg::CFG_NDR64_MODE, {31'd0, n64});
    cfg_beat(npe_pkg::CFG_NO_ALIGN, {31'd0, na});
    cfg_beat(npe_pkg::CFG_BUFFER_SIZE, bs);
    cfg_valid    <= 1'b0;
    mode_be      = be;
    mode_n64     = n64;
    mode_noalign = na;
    mode_bufsize = bs;
  endtask

  // ---- output side ---------------------------------------------------------

  // random ready; one long hold-off when asked, counted here
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        m_tready <= quiet || ($urandom_range(0, 99) >= 7);
      end
    end
  end

  // every accepted output beat against the oldest expectation
  always @(posedge clk) begin
    beat_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_stream.size() == 0) begin
        report_mismatch($sformatf("beat %0d, nothing expected", beat_index),
                        64'({m_tuser, m_tlast, m_tdata}), 64'd0);
      end else begin
        want = expected_stream.pop_front();
        if (m_tdata !== want.data)
          report_mismatch($sformatf("beat %0d out_byte", beat_index), 64'(m_tdata),
                          64'(want.data));
        if (m_tuser[0] !== want.valid)
          report_mismatch($sformatf("beat %0d byte_valid", beat_index), 64'(m_tuser[0]),
                          64'(want.valid));
        if (m_tlast !== want.last)
          report_mismatch($sformatf("beat %0d last", beat_index), 64'(m_tlast),
                          64'(want.last));
        if (m_tuser[1] !== want.status)
          report_mismatch($sformatf("beat %0d status", beat_index), 64'(m_tuser[1]),
                          64'(want.status));
      end
      beat_index++;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("ndr_primitive_encoder_test: done, errors");
      $finish;
    end
  end

  // ---- stimulus ------------------------------------------------------------

  initial begin
    row_t        r;
    logic [3:0]  cmd;
    logic [63:0] val;
    logic [3:0]  asz;
    logic [31:0] bs;
    int          item;

    // after reset: little endian, NDR, aligned, 4096 bytes
    dir_rows.push_back(typed_row(npe_pkg::CMD_BYTE, 64'hFFFF_FFFF_FFFF_FFA5, 4'd1, 5'd1,
                                 8'hA5, 1'b0));
    dir_rows.push_back(typed_row(npe_pkg::CMD_U16, 64'hFFFF_0000_FFFF_1234, 4'd1, 5'd3,
                                 8'h12, 1'b0));
    dir_rows.push_back(typed_row(npe_pkg::CMD_U32, 64'h0123_4567_DEAD_BEEF, 4'd1, 5'd4,
                                 8'hDE, 1'b0));
    dir_rows.push_back(typed_row(npe_pkg::CMD_U64, '1, 4'd8, 5'd8, 8'hFF, 1'b0));
    dir_rows.push_back(typed_row(npe_pkg::CMD_LONG, 64'h0000_0000_8000_0000, 4'd1, 5'd4,
                                 8'h80, 1'b0));
    dir_rows.push_back(cmd_row(npe_pkg::CMD_ALIGN, 64'd0, 4'd15));  // sizes above 8 act as 8
    dir_rows.push_back(typed_row(npe_pkg::CMD_ALIGN, 64'd0, 4'd0, 5'd1, 8'h00, 1'b0));
    dir_rows.push_back(cmd_row(npe_pkg::CMD_UPTR, 64'd0, 4'd1));    // null referent
    dir_rows.push_back(cmd_row(npe_pkg::CMD_UPTR, 64'd1, 4'd1));
    // trailer align is a no-op outside NDR64
    dir_rows.push_back(typed_row(npe_pkg::CMD_TRAILER, '1, 4'd8, 5'd1, 8'h00, 1'b0));
    dir_rows.push_back(typed_row(CMD_SPARE, '1, 4'd15, 5'd1, 8'h00, 1'b0));
    dir_rows.push_back(typed_row(npe_pkg::CMD_RESTART, 64'd0, 4'd1, 5'd1, 8'h00, 1'b0));
    // big endian NDR64: signed long widens, ulong at offset 9 pads seven bytes
    dir_rows.push_back(mode_row(1'b1, 1'b1, 1'b0, npe_pkg::BUFFER_SIZE_RESET));
    dir_rows.push_back(typed_row(npe_pkg::CMD_LONG, 64'h0000_0000_8000_0001, 4'd1, 5'd8,
                                 8'h01, 1'b0));
    dir_rows.push_back(cmd_row(npe_pkg::CMD_BYTE, 64'd1, 4'd1));
    dir_rows.push_back(typed_row(npe_pkg::CMD_ULONG, 64'hAAAA_AAAA_1234_5678, 4'd1, 5'd15,
                                 8'h78, 1'b0));
    dir_rows.push_back(cmd_row(npe_pkg::CMD_BYTE, 64'd2, 4'd1));
    dir_rows.push_back(cmd_row(npe_pkg::CMD_TRAILER, 64'd0, 4'd5));
    dir_rows.push_back(cmd_row(npe_pkg::CMD_UPTR, 64'h8000_0000_0000_0000, 4'd1));
    // no alignment, 6 bytes: u32 at offset 3 does not fit
    dir_rows.push_back(mode_row(1'b0, 1'b0, 1'b1, 32'd6));
    dir_rows.push_back(cmd_row(npe_pkg::CMD_RESTART, 64'd0, 4'd1));
    dir_rows.push_back(cmd_row(npe_pkg::CMD_U16, 64'h5A5A, 4'd1));
    dir_rows.push_back(cmd_row(npe_pkg::CMD_BYTE, 64'h3C, 4'd1));
    dir_rows.push_back(typed_row(npe_pkg::CMD_U32, '1, 4'd1, 5'd1, 8'h00, 1'b1));
    // 5 bytes: two pad bytes fit, then the u64 overflows
    dir_rows.push_back(mode_row(1'b0, 1'b0, 1'b0, 32'd5));
    dir_rows.push_back(cmd_row(npe_pkg::CMD_RESTART, 64'd0, 4'd1));
    dir_rows.push_back(cmd_row(npe_pkg::CMD_U16, 64'h1111, 4'd1));
    dir_rows.push_back(cmd_row(npe_pkg::CMD_BYTE, 64'h22, 4'd1));
    dir_rows.push_back(typed_row(npe_pkg::CMD_U64, '1, 4'd1, 5'd3, 8'h00, 1'b1));
    // empty buffer
    dir_rows.push_back(mode_row(1'b0, 1'b0, 1'b0, 32'd0));
    dir_rows.push_back(typed_row(npe_pkg::CMD_BYTE, 64'hFF, 4'd1, 5'd1, 8'h00, 1'b1));
    dir_rows.push_back(mode_row(1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF));
    dir_rows.push_back(cmd_row(npe_pkg::CMD_U64, 64'h0F1E_2D3C_4B5A_6978, 4'd1));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[k]) begin
      r = dir_rows[k];
      if (r.kind == ROW_MODE) begin
        set_mode(r.value[0], r.value[1], r.value[2], r.value[63:32]);
      end else begin
        send_command(r.cmd, r.value, r.asz);
        if (r.typed && (beats_of_cmd.size() != int'(r.t_count) ||
                        beats_of_cmd[$].data != r.t_data ||
                        beats_of_cmd[$].status != r.t_status))
          report_mismatch($sformatf("row %0d count/byte/status", k),
                          64'({beats_of_cmd.size(), beats_of_cmd[$].data,
                               beats_of_cmd[$].status}),
                          64'({r.t_count, r.t_data, r.t_status}));
      end
    end

    // random phases, each under its own register setting
    item = 0;
    for (int p = 0; p < RAND_PHASES; p++) begin
      case ($urandom_range(0, 3))
        0:       bs = $urandom;
        1:       bs = $urandom_range(8, 80);  // overflows come often
        2:       bs = 32'hFFFF_FFFF;
        default: bs = npe_pkg::BUFFER_SIZE_RESET;
      endcase
      if (p == 0) set_mode(1'b0, 1'b1, 1'b0, npe_pkg::BUFFER_SIZE_RESET);
      else if (p == 1) set_mode(1'b1, 1'b0, 1'b0, $urandom_range(8, 40));
      else set_mode(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                    $urandom_range(0, 3) == 0, bs);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        quiet = (item >= QUIET_FIRST && item < QUIET_END);
        if (item == HOLD_AT) hold_req <= 1'b1;
        if (i == 0) begin
          cmd = npe_pkg::CMD_RESTART;
        end else begin
          case ($urandom_range(0, 99)) inside
            [0:87]:  cmd = 4'($urandom_range(npe_pkg::CMD_BYTE, npe_pkg::CMD_UPTR));
            [88:95]: cmd = npe_pkg::CMD_RESTART;
            default: cmd = 4'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
          endcase
        end
        case ($urandom_range(0, 7))
          0:       val = 64'd0;
          1:       val = '1;
          default: val = {$urandom, $urandom};
        endcase
        asz = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15))
                                          : 4'($urandom_range(1, 8));
        send_command(cmd, val, asz);
        item++;
      end
    end

    s_tvalid <= 1'b0;
    quiet = 1'b0;
    while (expected_stream.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ndr_primitive_encoder_test: done, clean");
    end else begin
      $display("ndr_primitive_encoder_test: done, errors");
    end
    $finish;
  end

endmodule
